// File: rtl/srld_pkg.sv
// Package for the subpicture run-length line decoder.
// Types, codes and constants shared by all srld_* files; no dependencies.
package srld_pkg;

    // Field widths
    localparam int DIM_W    = 13;   // widths, heights, columns, line counters
    localparam int RUN_W    = 14;   // run length
    localparam int ALPHA_W  = 16;   // four 4-bit alpha values
    localparam int POS_W    = 26;   // product of two DIM_W values
    localparam int CODE_W   = 16;   // up to four nibbles
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Reset values of the registers
    localparam logic [DIM_W-1:0] WIDTH_RST = DIM_W'(720);
    localparam logic [DIM_W-1:0] COUNT_RST = DIM_W'(576);
    localparam logic [POS_W-1:0] TOTAL_RST = POS_W'(720 * 576);

    // Code thresholds: finished at 1, 2, 3 nibbles; fill and bad codes at 4
    localparam logic [CODE_W-1:0] CODE_MIN_1    = 16'h0004;
    localparam logic [CODE_W-1:0] CODE_MIN_2    = 16'h0010;
    localparam logic [CODE_W-1:0] CODE_MIN_3    = 16'h0040;
    localparam logic [CODE_W-1:0] CODE_SHORT_4  = 16'h0100;
    localparam logic [CODE_W-1:0] CODE_FILL_MAX = 16'h0004;
    localparam logic [1:0]        COLOR_MASK    = 2'h3;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_BAD_CODE = 2'd1,
        ERR_BEYOND   = 2'd2,
        ERR_OVERRUN  = 2'd3
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH = 2'd0,
        CFG_LINE_COUNT = 2'd1,
        CFG_ALPHA      = 2'd2
    } t_cfg_reg;

    // Decoder state carried from nibble to nibble
    typedef struct packed {
        logic [11:0]      partial;
        logic [1:0]       held;
        logic [DIM_W-1:0] column;
        logic [DIM_W-1:0] line_number;
        logic             still_top;
        logic [DIM_W-1:0] top_cnt;
        logic [DIM_W-1:0] bot_cnt;
        logic             halted;
        logic [POS_W-1:0] base;        // line_number * line_width
    } t_dec_state;

    // Picture setup seen by the nibble stage
    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   count;
        logic [ALPHA_W-1:0] alpha;
        logic [POS_W-1:0]   total;     // line_count * line_width
    } t_dec_cfg;

    // Per-nibble control flags
    typedef struct packed {
        logic emit;
        logic stop;
    } t_step;

    // One result item
    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic [1:0]       color_index;
        logic             kept;
        logic             line_end;
        logic             picture_done;
        t_err             error_code;
        logic [DIM_W-1:0] top_skipped;
        logic [DIM_W-1:0] bottom_skipped;
        logic             last_of_item;
    } t_run;

    // State after reset or a first byte
    function automatic t_dec_state srld_clear_state();
        t_dec_state s;
        s           = '0;
        s.still_top = 1'b1;
        return s;
    endfunction

endpackage

// File: rtl/srld_intf.sv
// Channel interfaces of the subpicture run-length line decoder.
// Depends on srld_pkg for field widths.
interface srld_in_if import srld_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, data_byte, first_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

interface srld_out_if import srld_pkg::*;;
    logic             valid;
    logic             ready;
    logic [RUN_W-1:0] run_length;
    logic [1:0]       color_index;
    logic             kept;
    logic             line_end;
    logic             picture_done;
    logic [1:0]       error_code;
    logic [DIM_W-1:0] top_skipped;
    logic [DIM_W-1:0] bottom_skipped;
    logic             last_of_item;

    modport source (output valid, run_length, color_index, kept, line_end, picture_done,
                    error_code, top_skipped, bottom_skipped, last_of_item, input ready);
    modport sink   (input valid, run_length, color_index, kept, line_end, picture_done,
                    error_code, top_skipped, bottom_skipped, last_of_item, output ready);
endinterface

interface srld_cfg_if import srld_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/srld_nibble.sv
// One nibble step of the run-length decoder: code building and run classification.
// Depends on srld_pkg.
module srld_nibble import srld_pkg::*; (
    input  logic       i_en,
    input  logic [3:0] i_nib,
    input  t_dec_cfg   i_cfg,
    input  t_dec_state i_state,
    output t_dec_state o_state,
    output t_run       o_run,
    output t_step      o_step
);

    logic [CODE_W-1:0] code;
    logic [2:0]        held;
    logic              done;
    logic              is_long;
    logic              is_fill;
    logic              is_bad;
    logic [RUN_W-1:0]  fill_len;
    logic [RUN_W-1:0]  len;
    logic [POS_W:0]    span;
    logic              beyond;
    logic [1:0]        col;
    logic [3:0]        alpha;
    logic              blank;
    logic [RUN_W:0]    newcol;
    logic [RUN_W:0]    width_x;
    logic [DIM_W-1:0]  next_line;

    // Code assembly and finish test
    assign code    = {i_state.partial, i_nib};
    assign held    = {1'b0, i_state.held} + 3'd1;
    assign is_long = (held == 3'd4);

    always_comb begin
        unique case (held)
            3'd1:    done = (code >= CODE_MIN_1);
            3'd2:    done = (code >= CODE_MIN_2);
            3'd3:    done = (code >= CODE_MIN_3);
            default: done = 1'b1;
        endcase
    end

    assign is_fill = is_long && (code < CODE_FILL_MAX);
    assign is_bad  = is_long && (code < CODE_SHORT_4) && !is_fill;

    // Run length: rest of the line for a fill code
    assign fill_len = (i_cfg.width > i_state.column)
                    ? {1'b0, i_cfg.width - i_state.column} : '0;
    assign len      = is_fill ? fill_len : code[CODE_W-1:2];
    assign col      = code[1:0] & COLOR_MASK;

    // Position checks
    assign span    = {{(POS_W+1-RUN_W){1'b0}}, len}
                   + {{(POS_W+1-DIM_W){1'b0}}, i_state.column}
                   + {1'b0, i_state.base};
    assign beyond  = span > {1'b0, i_cfg.total};
    assign newcol  = {1'b0, len} + {{(RUN_W+1-DIM_W){1'b0}}, i_state.column};
    assign width_x = {{(RUN_W+1-DIM_W){1'b0}}, i_cfg.width};

    assign alpha     = i_cfg.alpha[4*col +: 4];
    assign blank     = (len == {1'b0, i_cfg.width}) && (alpha == 4'd0);
    assign next_line = i_state.line_number + DIM_W'(1);

    always_comb begin
        o_state = i_state;
        o_run   = '0;
        o_step  = '0;
        if (i_en && !i_state.halted) begin
            if (!done) begin
                o_state.partial = code[11:0];
                o_state.held    = held[1:0];
            end else begin
                o_state.partial = '0;
                o_state.held    = '0;
                o_step.emit     = 1'b1;
                o_step.stop     = 1'b1;
                priority if (is_bad) begin
                    o_state.halted   = 1'b1;
                    o_run.error_code = ERR_BAD_CODE;
                end else if (beyond) begin
                    o_state.halted    = 1'b1;
                    o_run.run_length  = len;
                    o_run.color_index = col;
                    o_run.error_code  = ERR_BEYOND;
                end else begin
                    o_run.run_length  = len;
                    o_run.color_index = col;
                    // Blank line classification
                    if (blank) begin
                        if (i_state.still_top) begin
                            o_state.top_cnt = i_state.top_cnt + DIM_W'(1);
                            o_run.kept      = 1'b0;
                        end else begin
                            o_state.bot_cnt = i_state.bot_cnt + DIM_W'(1);
                            o_run.kept      = 1'b1;
                        end
                    end else begin
                        o_run.kept        = 1'b1;
                        o_state.still_top = 1'b0;
                        o_state.bot_cnt   = '0;
                    end
                    // Line position
                    priority if (newcol > width_x) begin
                        o_state.halted   = 1'b1;
                        o_run.error_code = ERR_OVERRUN;
                    end else if (newcol == width_x) begin
                        o_state.column      = '0;
                        o_state.line_number = next_line;
                        o_state.base        = (next_line == '0) ? '0
                                            : i_state.base + POS_W'(i_cfg.width);
                        o_run.line_end      = 1'b1;
                        o_run.picture_done  = (next_line == i_cfg.count);
                    end else begin
                        o_state.column = newcol[DIM_W-1:0];
                        o_step.stop    = 1'b0;
                    end
                end
            end
        end
        o_run.top_skipped    = o_state.top_cnt;
        o_run.bottom_skipped = o_state.bot_cnt;
    end

endmodule

// File: rtl/srld_run_fifo.sv
// Result queue: takes up to two runs a cycle, hands out one per transfer.
// Depends on srld_pkg.
module srld_run_fifo import srld_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push_n,
    input  t_run                  i_push_a,
    input  t_run                  i_push_b,
    input  logic                  i_pop,
    output t_run                  o_head,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_run                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_PTR_W-1:0] wr_next;

    assign wr_next = r_wr + FIFO_PTR_W'(1);

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_PTR_W'(i_push_n);
            r_rd    <= r_rd + FIFO_PTR_W'(i_pop);
            r_count <= r_count + FIFO_CNT_W'(i_push_n) - FIFO_CNT_W'(i_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_push_a;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr_next] <= i_push_b;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

// File: rtl/subpicture_rle_line_decoder.sv
// Top level of the subpicture run-length line decoder.
// Depends on srld_pkg, srld_intf, srld_nibble and srld_run_fifo.
//
// Takes one run-length byte per cycle while the input is not held off, high nibble
// first, and gives zero, one or two runs per byte. A byte is held in the input
// register and decoded there by two chained nibble stages. Its runs enter a
// four-entry result queue when the byte leaves the input register. The queue
// drains one run per cycle while the receiver is ready, so bytes are taken at
// one per cycle for as long as they average no more than one run each. The input
// register waits while fewer than two queue entries are free. A configuration
// write holds the input off in its own cycle and in the cycle after it. In
// that cycle two 13 x 13 multipliers recompute the start offset of the current
// line and the picture size.
module subpicture_rle_line_decoder import srld_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srld_in_if.sink    i_in,
    srld_cfg_if.sink   i_cfg,
    srld_out_if.source o_out
);

    // Registers
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_first;
    t_dec_state         r_state;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_count;
    logic [ALPHA_W-1:0] r_alpha;
    logic [POS_W-1:0]   r_total;
    logic               r_recalc;

    t_dec_cfg              w_cfg;
    t_dec_state            w_state_in;
    t_dec_state            w_state_a;
    t_dec_state            w_state_b;
    t_run                  w_run_a;
    t_run                  w_run_b;
    t_step                 w_step_a;
    t_step                 w_step_b;
    t_run                  w_push_a;
    t_run                  w_push_b;
    logic [1:0]            w_push_n;
    logic                  w_consume;
    logic                  w_cfg_wr;
    logic                  w_pop;
    t_run                  w_head;
    logic [FIFO_CNT_W-1:0] w_fifo_count;

    // Handshakes
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;
    assign w_consume   = r_in_valid && !r_recalc
                       && (w_fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign i_in.ready  = !r_recalc && !i_cfg.valid && (!r_in_valid || w_consume);
    assign w_pop       = o_out.valid && o_out.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte  <= i_in.data_byte;
            r_in_first <= i_in.first_byte;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_count  <= COUNT_RST;
            r_alpha  <= '0;
            r_recalc <= 1'b0;
        end else begin
            r_recalc <= w_cfg_wr;
            if (w_cfg_wr) begin
                unique case (t_cfg_reg'(i_cfg.index))
                    CFG_LINE_WIDTH: r_width <= i_cfg.data[DIM_W-1:0];
                    CFG_LINE_COUNT: r_count <= i_cfg.data[DIM_W-1:0];
                    CFG_ALPHA:      r_alpha <= i_cfg.data[ALPHA_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // Picture size product, refreshed after a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RST;
        end else if (r_recalc) begin
            r_total <= POS_W'(r_count) * POS_W'(r_width);
        end
    end

    // Decoder state; line start offset is refreshed after a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srld_clear_state();
        end else if (r_recalc) begin
            r_state.base <= POS_W'(r_state.line_number) * POS_W'(r_width);
        end else if (w_consume) begin
            r_state <= w_state_b;
        end
    end

    assign w_cfg.width = r_width;
    assign w_cfg.count = r_count;
    assign w_cfg.alpha = r_alpha;
    assign w_cfg.total = r_total;

    assign w_state_in = r_in_first ? srld_clear_state() : r_state;

    // Two chained nibble stages: high nibble, then low
    srld_nibble u_nib_hi (
        .i_en    (1'b1),
        .i_nib   (r_in_byte[7:4]),
        .i_cfg   (w_cfg),
        .i_state (w_state_in),
        .o_state (w_state_a),
        .o_run   (w_run_a),
        .o_step  (w_step_a)
    );

    srld_nibble u_nib_lo (
        .i_en    (!w_step_a.stop),
        .i_nib   (r_in_byte[3:0]),
        .i_cfg   (w_cfg),
        .i_state (w_state_a),
        .o_state (w_state_b),
        .o_run   (w_run_b),
        .o_step  (w_step_b)
    );

    // Pack emitted runs to the front and mark the last one of the byte
    always_comb begin
        w_push_a = w_step_a.emit ? w_run_a : w_run_b;
        w_push_b = w_run_b;
        w_push_a.last_of_item = !(w_step_a.emit && w_step_b.emit);
        w_push_b.last_of_item = 1'b1;
        if (w_consume) begin
            w_push_n = {1'b0, w_step_a.emit} + {1'b0, w_step_b.emit};
        end else begin
            w_push_n = 2'd0;
        end
    end

    srld_run_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_push_a (w_push_a),
        .i_push_b (w_push_b),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_count  (w_fifo_count)
    );

    // Output channel
    assign o_out.valid          = (w_fifo_count != '0);
    assign o_out.run_length     = w_head.run_length;
    assign o_out.color_index    = w_head.color_index;
    assign o_out.kept           = w_head.kept;
    assign o_out.line_end       = w_head.line_end;
    assign o_out.picture_done   = w_head.picture_done;
    assign o_out.error_code     = w_head.error_code;
    assign o_out.top_skipped    = w_head.top_skipped;
    assign o_out.bottom_skipped = w_head.bottom_skipped;
    assign o_out.last_of_item   = w_head.last_of_item;

    // A halted decoder gives no runs for a byte without the first flag
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_state.halted && !r_in_first) |-> (w_push_n == 2'd0))
        else $error("runs emitted while halted");

    // Halt holds until a first byte is decoded
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.halted && !(w_consume && r_in_first)) |=> r_state.halted)
        else $error("halt released without first byte");

    // A completed line leaves the column at zero
    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && w_push_n != 2'd0 && w_step_a.emit && w_run_a.line_end)
        |=> (r_state.column == '0))
        else $error("column not cleared at line end");

endmodule

// File: verif/subpicture_rle_line_decoder_tb.sv
// Self-checking testbench for subpicture_rle_line_decoder.
// Drives RLE bytes and register writes, predicts every run and checks the results in order.
// Depends on srld_pkg, srld_intf and the decoder RTL.
`timescale 1ns / 1ps

module subpicture_rle_line_decoder_tb;
    import srld_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int STALL_LIMIT   = 1000;  // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES = 8;     // quiet cycles once the run queue is empty
    localparam int RANDOM_BYTES  = 800;
    localparam int MAX_CODE_RUN  = 255;   // longest run the tests encode; a 4-nibble code can carry up to 16383

    logic i_clk = 1'b0;
    logic i_rst_n;

    srld_in_if  in_ch ();
    srld_cfg_if cfg_ch ();
    srld_out_if run_ch ();

    subpicture_rle_line_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (run_ch)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Register copy and decoder state of the prediction
    logic [DIM_W-1:0]   cfg_width;
    logic [DIM_W-1:0]   cfg_count;
    logic [ALPHA_W-1:0] cfg_alpha;
    logic [11:0]        dec_partial;
    logic [1:0]         dec_held;
    logic [DIM_W-1:0]   dec_column;
    logic [DIM_W-1:0]   dec_line;
    logic               dec_top_blank;
    logic [DIM_W-1:0]   dec_top_cnt;
    logic [DIM_W-1:0]   dec_bot_cnt;
    logic               dec_halted;

    t_run       pending_runs[$];    // runs predicted but not yet seen
    logic [3:0] rle_nibbles[$];     // nibbles of the line being built
    int         live_bytes = 0;     // bytes the decoder did not ignore
    int         mismatches = 0;
    bit         gaps_on = 1'b1;
    int         sink_hold = 0;      // long hold-off requested of the receiver

    function automatic void clear_decoder();
        dec_partial   = '0;
        dec_held      = '0;
        dec_column    = '0;
        dec_line      = '0;
        dec_top_blank = 1'b1;
        dec_top_cnt   = '0;
        dec_bot_cnt   = '0;
        dec_halted    = 1'b0;
    endfunction

    function automatic void restore_defaults();
        cfg_width = WIDTH_RST;
        cfg_count = COUNT_RST;
        cfg_alpha = '0;
        clear_decoder();
    endfunction

    function automatic void queue_run(int unsigned len, logic [1:0] color, logic kept,
                                      logic line_end, logic pic_done, t_err err);
        t_run r;
        r.run_length     = len[RUN_W-1:0];
        r.color_index    = color;
        r.kept           = kept;
        r.line_end       = line_end;
        r.picture_done   = pic_done;
        r.error_code     = err;
        r.top_skipped    = dec_top_cnt;
        r.bottom_skipped = dec_bot_cnt;
        r.last_of_item   = 1'b0;
        pending_runs.push_back(r);
    endfunction

    // Decode one transferred byte, high nibble first, and queue the runs it gives
    function automatic void decode_byte(logic [7:0] rle_byte, logic first);
        logic [3:0]        nib;
        logic [15:0]       code;
        int unsigned       held;
        int unsigned       len;
        int unsigned       newcol;
        logic [1:0]        color;
        logic [3:0]        alpha;
        logic              done;
        logic              bad;
        logic              kept;
        logic              stop;
        longint unsigned   end_pos;
        longint unsigned   total;
        int                runs_before;
        t_run              last_run;

        if (first)
            clear_decoder();
        if (dec_halted)
            return;
        live_bytes++;
        runs_before = pending_runs.size();
        stop = 1'b0;
        for (int i = 0; i < 2 && !stop; i++) begin
            nib  = (i == 0) ? rle_byte[7:4] : rle_byte[3:0];
            code = {dec_partial, nib};
            held = int'(dec_held) + 1;
            case (held)
                1:       done = (code >= CODE_MIN_1);
                2:       done = (code >= CODE_MIN_2);
                3:       done = (code >= CODE_MIN_3);
                default: done = 1'b1;
            endcase
            if (!done) begin
                dec_partial = code[11:0];
                dec_held    = held[1:0];
            end else begin
                dec_partial = '0;
                dec_held    = '0;
                color = code[1:0];
                bad   = (held == 4) && (code < CODE_SHORT_4) && (code >= CODE_FILL_MAX);
                // short 4-nibble code fills the rest of the line
                if (held == 4 && code < CODE_FILL_MAX)
                    len = (cfg_width > dec_column) ? cfg_width - dec_column : 0;
                else
                    len = code >> 2;
                end_pos = len;
                end_pos += dec_column;
                end_pos += longint'(dec_line) * cfg_width;
                total   = longint'(cfg_count) * cfg_width;
                if (bad) begin
                    dec_halted = 1'b1;
                    queue_run(0, 2'd0, 1'b0, 1'b0, 1'b0, ERR_BAD_CODE);
                    stop = 1'b1;
                end else if (end_pos > total) begin
                    dec_halted = 1'b1;
                    queue_run(len, color, 1'b0, 1'b0, 1'b0, ERR_BEYOND);
                    stop = 1'b1;
                end else begin
                    // full-width transparent run: blank line at top or bottom
                    alpha = cfg_alpha[4*color +: 4];
                    if (len == cfg_width && alpha == 4'h0) begin
                        if (dec_top_blank) begin
                            dec_top_cnt++;
                            kept = 1'b0;
                        end else begin
                            dec_bot_cnt++;
                            kept = 1'b1;
                        end
                    end else begin
                        kept          = 1'b1;
                        dec_top_blank = 1'b0;
                        dec_bot_cnt   = '0;
                    end
                    newcol = dec_column + len;
                    if (newcol > cfg_width) begin
                        dec_halted = 1'b1;
                        queue_run(len, color, kept, 1'b0, 1'b0, ERR_OVERRUN);
                        stop = 1'b1;
                    end else if (newcol == cfg_width) begin
                        dec_column = '0;
                        dec_line++;
                        queue_run(len, color, kept, 1'b1, dec_line == cfg_count, ERR_OK);
                        stop = 1'b1;
                    end else begin
                        dec_column = newcol[DIM_W-1:0];
                        queue_run(len, color, kept, 1'b0, 1'b0, ERR_OK);
                    end
                end
            end
        end
        if (pending_runs.size() > runs_before) begin
            last_run = pending_runs.pop_back();
            last_run.last_of_item = 1'b1;
            pending_runs.push_back(last_run);
        end
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 96)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte, hold it until the transfer, then predict its runs
    task automatic send_byte(logic [7:0] rle_byte, logic first);
        int unsigned gap;
        gap = gaps_on ? gap_cycles() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= rle_byte;
        in_ch.first_byte <= first;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        decode_byte(rle_byte, first);
    endtask

    // Stop sending and wait until every predicted run has been seen
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DAT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            CFG_LINE_WIDTH: cfg_width = value[DIM_W-1:0];
            CFG_LINE_COUNT: cfg_count = value[DIM_W-1:0];
            CFG_ALPHA:      cfg_alpha = value;
            default: ;
        endcase
    endtask

    // Picture setup is only changed with the decoder idle
    task automatic write_setup(int unsigned width, int unsigned count, logic [15:0] alpha);
        wait_drained();
        write_reg(CFG_LINE_WIDTH, CFG_DAT_W'(width));
        write_reg(CFG_LINE_COUNT, CFG_DAT_W'(count));
        write_reg(CFG_ALPHA, alpha);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void encode_run(int unsigned len, logic [1:0] color);
        logic [15:0] code;
        code = 16'((len << 2) | color);
        if (len >= 64)
            rle_nibbles.push_back(code[15:12]);
        if (len >= 16)
            rle_nibbles.push_back(code[11:8]);
        if (len >= 4)
            rle_nibbles.push_back(code[7:4]);
        rle_nibbles.push_back(code[3:0]);
    endfunction

    function automatic void encode_fill(logic [1:0] color);
        rle_nibbles.push_back(4'h0);
        rle_nibbles.push_back(4'h0);
        rle_nibbles.push_back(4'h0);
        rle_nibbles.push_back({2'b00, color});
    endfunction

    function automatic int unsigned pick_run_length();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 3);
            1:       return $urandom_range(4, 15);
            2:       return $urandom_range(16, 63);
            default: return $urandom_range(64, MAX_CODE_RUN);
        endcase
    endfunction

    // One line of codes: a fill code, single full run, mixed runs, or an overrunning line
    function automatic void build_line(int unsigned width);
        int unsigned kind;
        int unsigned remaining;
        int unsigned len;
        logic        broken;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            encode_fill(2'($urandom_range(0, 3)));
        end else if (kind < 40 && width <= MAX_CODE_RUN) begin
            encode_run(width, 2'($urandom_range(0, 3)));
        end else begin
            remaining = width;
            broken    = (kind >= 90);
            while (remaining > 0) begin
                if ($urandom_range(0, 4) == 0) begin
                    encode_fill(2'($urandom_range(0, 3)));
                    remaining = 0;
                end else begin
                    len = pick_run_length();
                    if (len > remaining)
                        len = broken ? remaining + $urandom_range(1, 8) : remaining;
                    if (len > MAX_CODE_RUN)
                        len = MAX_CODE_RUN;
                    encode_run(len, 2'($urandom_range(0, 3)));
                    remaining = (len >= remaining) ? 0 : remaining - len;
                end
            end
        end
    endfunction

    // Pack the built nibbles into bytes; the nibble after a line end is don't-care
    task automatic send_nibbles(logic first);
        if (rle_nibbles.size() % 2 != 0)
            rle_nibbles.push_back(4'($urandom_range(0, 15)));
        for (int k = 0; k < rle_nibbles.size(); k += 2)
            send_byte({rle_nibbles[k], rle_nibbles[k+1]}, first && (k == 0));
        rle_nibbles.delete();
    endtask

    // Registers at their reset values: top blank line, then 3- and 1-nibble codes
    task automatic test_reset_setup();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0B, 1'b0);
        send_byte(8'h4F, 1'b0);
    endtask

    // Every code length, a fill to line end, a line overrun, then a byte ignored while halted
    task automatic test_code_lengths();
        write_setup(40, 3, 16'hFFFF);
        send_byte(8'h45, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Short 4-nibble code that is not a fill
    task automatic test_bad_code();
        send_byte(8'h00, 1'b1);
        send_byte(8'h40, 1'b0);
        send_byte(8'h12, 1'b0);
    endtask

    // Dropped top blank, last line of the picture, then a run beyond the picture
    task automatic test_picture_limits();
        write_setup(4, 2, 16'h000F);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h45, 1'b0);
    endtask

    // Width lowered mid-line: zero-length fill that ends the line, then one that overruns
    task automatic test_width_change();
        write_setup(16, 4, 16'hFFFF);
        send_byte(8'h28, 1'b1);
        write_setup(10, 4, 16'hFFFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h1C, 1'b0);
        write_setup(4, 4, 16'hFFFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
    endtask

    // Receiver holds off while two runs per byte fill the queue and stall the input
    task automatic test_backpressure();
        write_setup(4096, 4096, 16'hFFFF);
        gaps_on   = 1'b0;
        sink_hold = 80;
        for (int k = 0; k < 24; k++)
            send_byte(8'h44, k == 0);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // Random pictures of well-formed lines, with some broken lines and raw noise
    task automatic test_random_pictures();
        int unsigned width;
        int unsigned count;
        int unsigned lines;
        logic [15:0] alpha;
        int          target;
        bit          first_pic;
        target    = live_bytes + RANDOM_BYTES;
        first_pic = 1'b1;
        while (live_bytes < target) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       width = 4096;
                1:       width = 1;
                2, 3:    width = $urandom_range(41, MAX_CODE_RUN);
                4:       width = $urandom_range(MAX_CODE_RUN + 1, 4096);
                default: width = $urandom_range(2, 40);
            endcase
            case ($urandom_range(0, 7))
                0:       count = 4096;
                1:       count = 1;
                2:       count = $urandom_range(7, 4095);
                default: count = $urandom_range(2, 6);
            endcase
            alpha = 16'($urandom_range(0, 65535));
            for (int n = 0; n < 4; n++)
                if ($urandom_range(0, 1) == 0)
                    alpha[4*n +: 4] = 4'h0;
            if (first_pic) begin
                width = 4096;
                count = 4096;
                alpha = 16'h0000;
            end
            first_pic = 1'b0;
            write_setup(width, count, alpha);
            if ($urandom_range(0, 9) == 0) begin
                // raw bytes, first-byte flag now and then
                for (int k = 0; k < 12; k++)
                    send_byte(8'($urandom_range(0, 255)),
                              (k == 0) || ($urandom_range(0, 7) == 0));
            end else begin
                lines = $urandom_range(1, ((count < 6) ? count : 6) + 1);
                for (int l = 0; l < lines; l++) begin
                    build_line(width);
                    send_nibbles(l == 0);
                end
            end
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each run transfer with the oldest prediction
    always @(posedge i_clk) begin : check_runs
        t_run want;
        if (i_rst_n && run_ch.valid && run_ch.ready) begin
            if (pending_runs.size() == 0) begin
                $error("run_length: expected no run, got %0d", run_ch.run_length);
                mismatches++;
            end else begin
                want = pending_runs.pop_front();
                check_field("run_length", want.run_length, run_ch.run_length);
                check_field("color_index", want.color_index, run_ch.color_index);
                check_field("kept", want.kept, run_ch.kept);
                check_field("line_end", want.line_end, run_ch.line_end);
                check_field("picture_done", want.picture_done, run_ch.picture_done);
                check_field("error_code", want.error_code, run_ch.error_code);
                check_field("top_skipped", want.top_skipped, run_ch.top_skipped);
                check_field("bottom_skipped", want.bottom_skipped, run_ch.bottom_skipped);
                check_field("last_of_item", want.last_of_item, run_ch.last_of_item);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one
    initial begin : run_sink
        int unsigned stall_left;
        stall_left = 0;
        run_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                run_ch.ready <= 1'b0;
                sink_hold--;
            end else if (stall_left > 0) begin
                run_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                run_ch.ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 2) == 0)
                    stall_left = gap_cycles();
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (run_ch.valid && run_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("subpicture_rle_line_decoder_tb NOT OK");
        $finish;
    end

    // Main sequence
    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.data_byte  <= 8'h00;
        in_ch.first_byte <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_LINE_WIDTH;
        cfg_ch.data      <= '0;
        restore_defaults();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_setup();
        test_code_lengths();
        test_bad_code();
        test_picture_limits();
        test_width_change();
        test_backpressure();
        test_random_pictures();
        wait_drained();

        if (mismatches == 0 && pending_runs.size() == 0)
            $display("subpicture_rle_line_decoder_tb OK");
        else
            $display("subpicture_rle_line_decoder_tb NOT OK");
        $finish;
    end

endmodule

// File: subpicture_rle_line_decoder.f
rtl/srld_pkg.sv
rtl/srld_intf.sv
rtl/srld_nibble.sv
rtl/srld_run_fifo.sv
rtl/subpicture_rle_line_decoder.sv
verif/subpicture_rle_line_decoder_tb.sv
